>>> design/rgbf_pkg.sv
// ----------------------------------------------------------------------------
// rgbf_pkg
// Shared constants, types and the channel blend for the RGB555 color fade.
// ----------------------------------------------------------------------------
package rgbf_pkg;

    localparam int unsigned WEIGHT_BITS = 9;     // weight 0..256
    localparam int unsigned CHAN_BITS   = 5;
    localparam int unsigned COLOR_BITS  = 16;
    localparam int unsigned PHASE_BITS  = 16;
    localparam int unsigned APB_AW      = 4;

    localparam logic [WEIGHT_BITS-1:0] WEIGHT_ONE = 9'd256;
    localparam logic [CHAN_BITS-1:0]   CHAN_MASK  = 5'h1F;

    // register indexes (byte address / 4)
    localparam logic [1:0] REG_START_COLOR  = 2'd0;
    localparam logic [1:0] REG_END_COLOR    = 2'd1;
    localparam logic [1:0] REG_CYCLE_LENGTH = 2'd2;
    localparam logic [1:0] REG_CURVE_MODE   = 2'd3;

    localparam logic [15:0] RST_START_COLOR  = 16'd0;
    localparam logic [15:0] RST_END_COLOR    = 16'd32767;
    localparam logic [15:0] RST_CYCLE_LENGTH = 16'd256;

    typedef logic [CHAN_BITS-1:0]   t_chan;
    typedef logic [WEIGHT_BITS-1:0] t_weight;

    // s + trunc((e - s) * w / 256), signed truncation toward zero
    function automatic t_chan blend_chan(input t_chan s, input t_chan e, input t_weight w);
        logic signed [5:0]  di;
        logic signed [15:0] prod;
        logic signed [15:0] adj;
        logic signed [7:0]  q;
        logic [7:0]         sum;
        di   = $signed({1'b0, e}) - $signed({1'b0, s});
        prod = 16'(di * $signed({1'b0, w}));
        adj  = prod[15] ? (prod + 16'sd255) : prod;
        q    = 8'(adj >>> 8);
        sum  = 8'({3'b000, s}) + 8'(q);
        return sum[CHAN_BITS-1:0];
    endfunction

endpackage

>>> design/rgbf_phase_if.sv
// ----------------------------------------------------------------------------
// rgbf_phase_if
// Phase input channel: valid/ready handshake with one phase value per beat.
// ----------------------------------------------------------------------------
interface rgbf_phase_if;
    logic        valid;
    logic        ready;
    logic [15:0] phase_value;

    modport source (output valid, output phase_value, input ready);
    modport sink   (input valid, input phase_value, output ready);
endinterface

>>> design/rgbf_color_if.sv
// ----------------------------------------------------------------------------
// rgbf_color_if
// Color output channel: valid/ready handshake with one RGB555 color per beat.
// ----------------------------------------------------------------------------
interface rgbf_color_if;
    logic        valid;
    logic        ready;
    logic [15:0] blended_color;

    modport source (output valid, output blended_color, input ready);
    modport sink   (input valid, input blended_color, output ready);
endinterface

>>> design/rgb555_triangle_color_fade.sv
// ----------------------------------------------------------------------------
// rgb555_triangle_color_fade
// Triangle-wave weight from a phase, optional cubic easing, RGB555 blend.
// ----------------------------------------------------------------------------
//  channel     dir  handshake      payload
//  i_phase     in   valid/ready    phase_value   [15:0]
//  o_color     out  valid/ready    blended_color [15:0]
//  apb         in   psel/penable   pwdata [31:0], paddr [3:0]
//
// One beat per cycle while the output is not stalled. In order, the stages are
// the bit-serial phase modulo, numerator setup, the weight divider, the
// easing multipliers and the blend into the output register.
// Synchronous active-low reset clears all valid bits and the configuration registers.
// A stall at the output freezes the whole pipeline; nothing is dropped.
// ----------------------------------------------------------------------------
module rgb555_triangle_color_fade
    import rgbf_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    rgbf_phase_if.sink         i_phase,
    rgbf_color_if.source       o_color,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [APB_AW-1:0]  paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int unsigned MOD_N = PHASE_BITS;   // modulo steps
    localparam int unsigned DIV_N = WEIGHT_BITS;  // weight quotient bits

    // ---------------- configuration ----------------
    logic [15:0] r_start_color;
    logic [15:0] r_end_color;
    logic [15:0] r_cycle_length;
    logic        r_curve_mode;
    logic        w_wr;
    logic [1:0]  w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    assign w_idx  = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_color  <= RST_START_COLOR;
            r_end_color    <= RST_END_COLOR;
            r_cycle_length <= RST_CYCLE_LENGTH;
            r_curve_mode   <= 1'b0;
        end else if (w_wr) begin
            case (w_idx)
                REG_START_COLOR:  r_start_color  <= pwdata[15:0];
                REG_END_COLOR:    r_end_color    <= pwdata[15:0];
                REG_CYCLE_LENGTH: r_cycle_length <= pwdata[15:0];
                REG_CURVE_MODE:   r_curve_mode   <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_START_COLOR:  prdata = {16'd0, r_start_color};
            REG_END_COLOR:    prdata = {16'd0, r_end_color};
            REG_CYCLE_LENGTH: prdata = {16'd0, r_cycle_length};
            REG_CURVE_MODE:   prdata = {31'd0, r_curve_mode};
            default:          prdata = 32'd0;
        endcase
    end

    // ---------------- pipeline control ----------------
    logic w_en;
    logic r_out_vld;

    assign w_en          = ~r_out_vld | o_color.ready;
    assign i_phase.ready = w_en;

    // ---------------- phase modulo (restoring, one bit per stage) ----------
    logic [15:0] r_m_rem [0:MOD_N];
    logic [15:0] r_m_div [0:MOD_N];
    logic        r_m_vld [0:MOD_N];
    logic [15:0] n_m_rem [1:MOD_N];

    always_comb begin
        for (int k = 0; k < MOD_N; k++) begin
            logic [16:0] t17;
            t17 = {r_m_rem[k], r_m_div[k][15]};
            if (t17 >= {1'b0, r_cycle_length}) begin
                t17 = t17 - {1'b0, r_cycle_length};
            end
            n_m_rem[k+1] = t17[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= MOD_N; k++) r_m_vld[k] <= 1'b0;
        end else if (w_en) begin
            r_m_vld[0] <= i_phase.valid;
            for (int k = 1; k <= MOD_N; k++) r_m_vld[k] <= r_m_vld[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m_rem[0] <= 16'd0;
            r_m_div[0] <= i_phase.phase_value;
            for (int k = 1; k <= MOD_N; k++) begin
                r_m_rem[k] <= n_m_rem[k];
                r_m_div[k] <= {r_m_div[k-1][14:0], 1'b0};
            end
        end
    end

    // ---------------- numerator setup ----------------
    // quotient stays below 512, so start the divider on x >> 1
    logic [14:0] w_half;
    logic [15:0] w_ph;
    logic [15:0] w_x;

    assign w_half = r_cycle_length[15:1];
    assign w_ph   = r_m_rem[MOD_N];
    assign w_x    = (w_ph <= {1'b0, w_half}) ? w_ph : (r_cycle_length - w_ph);

    logic [15:0]      r_d_rem  [0:DIV_N];
    logic [DIV_N-1:0] r_d_bits [0:DIV_N];
    logic [DIV_N-1:0] r_d_q    [0:DIV_N];
    logic             r_d_zero [0:DIV_N];
    logic             r_d_vld  [0:DIV_N];
    logic [15:0]      n_d_rem  [1:DIV_N];
    logic             n_d_qb   [1:DIV_N];

    always_comb begin
        for (int j = 0; j < DIV_N; j++) begin
            logic [16:0] t17;
            t17 = {r_d_rem[j], r_d_bits[j][DIV_N-1]};
            n_d_qb[j+1] = (t17 >= {2'b00, w_half});
            if (n_d_qb[j+1]) begin
                t17 = t17 - {2'b00, w_half};
            end
            n_d_rem[j+1] = t17[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j <= DIV_N; j++) r_d_vld[j] <= 1'b0;
        end else if (w_en) begin
            r_d_vld[0] <= r_m_vld[MOD_N];
            for (int j = 1; j <= DIV_N; j++) r_d_vld[j] <= r_d_vld[j-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d_rem[0]  <= {1'b0, w_x[15:1]};
            r_d_bits[0] <= {w_x[0], {(DIV_N-1){1'b0}}};
            r_d_q[0]    <= '0;
            r_d_zero[0] <= (w_half == 15'd0);
            for (int j = 1; j <= DIV_N; j++) begin
                r_d_rem[j]  <= n_d_rem[j];
                r_d_bits[j] <= {r_d_bits[j-1][DIV_N-2:0], 1'b0};
                r_d_q[j]    <= {r_d_q[j-1][DIV_N-2:0], n_d_qb[j]};
                r_d_zero[j] <= r_d_zero[j-1];
            end
        end
    end

    // ---------------- easing ----------------
    t_weight     w_tri;
    t_weight     r_e1_t, r_e2_t;
    logic [16:0] r_e1_t2;
    logic [26:0] r_e2_a;
    logic [25:0] r_e2_b;
    t_weight     r_e3_w;
    logic        r_e1_vld, r_e2_vld, r_e3_vld;
    logic [9:0]  w_inv3;
    logic [27:0] w_sum;
    t_weight     w_ease;

    assign w_tri  = r_d_zero[DIV_N] ? '0 : r_d_q[DIV_N];
    assign w_inv3 = 10'(3 * (WEIGHT_ONE - r_e1_t));
    assign w_sum  = {1'b0, r_e2_a} + {2'b00, r_e2_b};
    assign w_ease = (w_sum[27:16] >= 12'd256) ? WEIGHT_ONE : w_sum[24:16];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e1_vld  <= 1'b0;
            r_e2_vld  <= 1'b0;
            r_e3_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_e1_vld  <= r_d_vld[DIV_N];
            r_e2_vld  <= r_e1_vld;
            r_e3_vld  <= r_e2_vld;
            r_out_vld <= r_e3_vld;
        end
    end

    // ---------------- blend ----------------
    logic [15:0] r_out_color;
    logic [15:0] w_blend;

    assign w_blend = r_e3_w[8] ? r_end_color :
        {1'b0,
         blend_chan(r_start_color[14:10] & CHAN_MASK, r_end_color[14:10], r_e3_w),
         blend_chan(r_start_color[9:5]   & CHAN_MASK, r_end_color[9:5],   r_e3_w),
         blend_chan(r_start_color[4:0]   & CHAN_MASK, r_end_color[4:0],   r_e3_w)};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e1_t      <= w_tri;
            r_e1_t2     <= 17'({8'd0, w_tri} * {8'd0, w_tri});
            r_e2_t      <= r_e1_t;
            r_e2_a      <= 27'(w_inv3 * r_e1_t2);
            r_e2_b      <= 26'(r_e1_t2 * r_e1_t);
            r_e3_w      <= r_curve_mode ? w_ease : r_e2_t;
            r_out_color <= w_blend;
        end
    end

    assign o_color.valid         = r_out_vld;
    assign o_color.blended_color = r_out_color;

endmodule
